>>> hw/rtl/d2p_pkg.sv
// Constants and character lookup functions shared by the DER to PEM encoder.
package d2p_pkg;

    localparam int HDR_LEN  = 28;
    localparam int FTR_LEN  = 26;
    localparam int QUAD_LEN = 4;
    localparam int LINE_COLUMNS = 64;

    localparam logic [8*HDR_LEN-1:0] BEGIN_TEXT = "-----BEGIN CERTIFICATE-----\n";
    localparam logic [8*FTR_LEN-1:0] END_TEXT   = "-----END CERTIFICATE-----\n";

    localparam logic [7:0] CHAR_PAD     = 8'h3d;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // Standard base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

    function automatic logic [7:0] begin_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < HDR_LEN) begin
            c = BEGIN_TEXT[8*(HDR_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < FTR_LEN) begin
            c = END_TEXT[8*(FTR_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/d2p_if.sv
// Valid/ready channel interfaces for DER input bytes and PEM output characters.
interface d2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface d2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_block;

    modport source (output valid, output out_char, output end_of_block, input ready);
    modport sink   (input valid, input out_char, input end_of_block, output ready);
endinterface

>>> hw/rtl/der_to_pem_base64_encoder_unit.sv
// DER to PEM encoder: takes one certificate byte per item and sends the PEM text
// one character per item. Each accepted byte is turned at once into a character
// job (header line, one base64 quad, a newline, footer line, each as needed) and
// the job is sent by a character sequencer, one character per cycle while the
// output is taken, through an output register. A byte is accepted in the same
// cycle that the previous job sends its last character, so for steady base64
// data a group of three bytes is collected and its quad goes out before the
// next byte is taken, and a line break follows every 48 bytes. The first byte
// of a certificate holds the input while the header line goes out and the final
// byte while its last quad, newline and footer line go out, as needed. Bytes
// that only fill the group send nothing. The sequencer stalls while a character
// in the output register waits to be taken.
module der_to_pem_base64_encoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    d2p_in_if.sink           i_in,
    d2p_out_if.source        o_out
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_QUAD = 5'b00100,
        PH_NL   = 5'b01000,
        PH_FTR  = 5'b10000
    } t_phase;

    // Encoder state.
    logic        r_header_sent, n_header_sent;
    logic [15:0] r_group_bytes, n_group_bytes;
    logic [1:0]  r_group_fill, n_group_fill;
    logic [5:0]  r_line_column, n_line_column;

    // Character job.
    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic        r_quad_en, r_nl_en, r_ftr_en;
    logic [31:0] r_quad_chars;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_eob;

    // Job built from the incoming byte.
    logic        w_hdr, w_quad, w_nl, w_ftr;
    logic [23:0] w_quad_v;
    logic [1:0]  w_quad_nb;
    logic [15:0] w_gb_mid;
    logic [1:0]  w_fill_mid;
    logic [6:0]  w_col_sum;
    logic [5:0]  w_col_after;
    logic [31:0] w_quad_chars;
    t_phase      w_first_phase;

    logic        w_advance, w_phase_last, w_job_last, w_accept;
    t_phase      w_after_phase;
    logic [7:0]  w_char;
    logic        w_eob;

    always_comb begin
        w_hdr      = !r_header_sent;
        w_quad     = 1'b0;
        w_quad_v   = 24'h0;
        w_quad_nb  = 2'd3;
        w_gb_mid   = 16'h0;
        w_fill_mid = 2'd0;
        case (r_group_fill)
            2'd2: begin
                w_quad   = 1'b1;
                w_quad_v = {r_group_bytes, i_in.data_byte};
            end
            2'd1: begin
                w_gb_mid   = {r_group_bytes[15:8], i_in.data_byte};
                w_fill_mid = 2'd2;
            end
            default: begin
                w_gb_mid   = {i_in.data_byte, 8'h00};
                w_fill_mid = 2'd1;
            end
        endcase
        // A partial group on the final byte goes out padded.
        if (i_in.final_byte && w_fill_mid != 2'd0) begin
            w_quad    = 1'b1;
            w_quad_v  = {w_gb_mid, 8'h00};
            w_quad_nb = w_fill_mid;
        end

        w_col_sum   = {1'b0, r_line_column} + (w_quad ? 7'd4 : 7'd0);
        w_col_after = (w_col_sum >= 7'(d2p_pkg::LINE_COLUMNS)) ? 6'd0 : w_col_sum[5:0];
        w_nl        = (w_col_sum >= 7'(d2p_pkg::LINE_COLUMNS))
                      || (i_in.final_byte && w_col_after != 6'd0);
        w_ftr       = i_in.final_byte;

        w_quad_chars[31:24] = d2p_pkg::b64_char(w_quad_v[23:18]);
        w_quad_chars[23:16] = d2p_pkg::b64_char(w_quad_v[17:12]);
        w_quad_chars[15:8]  = (w_quad_nb > 2'd1) ? d2p_pkg::b64_char(w_quad_v[11:6])
                                                 : d2p_pkg::CHAR_PAD;
        w_quad_chars[7:0]   = (w_quad_nb > 2'd2) ? d2p_pkg::b64_char(w_quad_v[5:0])
                                                 : d2p_pkg::CHAR_PAD;

        if (w_hdr) begin
            w_first_phase = PH_HDR;
        end else if (w_quad) begin
            w_first_phase = PH_QUAD;
        end else if (w_nl) begin
            w_first_phase = PH_NL;
        end else if (w_ftr) begin
            w_first_phase = PH_FTR;
        end else begin
            w_first_phase = PH_IDLE;
        end

        if (i_in.final_byte) begin
            n_header_sent = 1'b0;
            n_group_bytes = 16'h0;
            n_group_fill  = 2'd0;
            n_line_column = 6'd0;
        end else begin
            n_header_sent = 1'b1;
            n_group_bytes = w_gb_mid;
            n_group_fill  = w_fill_mid;
            n_line_column = w_col_after;
        end
    end

    // Character sequencer.
    always_comb begin
        w_char        = 8'h00;
        w_eob         = 1'b0;
        w_phase_last  = 1'b0;
        w_after_phase = PH_IDLE;
        case (r_phase)
            PH_HDR: begin
                w_char       = d2p_pkg::begin_char(r_pos);
                w_phase_last = (r_pos == 5'(d2p_pkg::HDR_LEN - 1));
                if (r_quad_en) begin
                    w_after_phase = PH_QUAD;
                end else if (r_nl_en) begin
                    w_after_phase = PH_NL;
                end else if (r_ftr_en) begin
                    w_after_phase = PH_FTR;
                end
            end
            PH_QUAD: begin
                case (r_pos[1:0])
                    2'd0:    w_char = r_quad_chars[31:24];
                    2'd1:    w_char = r_quad_chars[23:16];
                    2'd2:    w_char = r_quad_chars[15:8];
                    default: w_char = r_quad_chars[7:0];
                endcase
                w_phase_last = (r_pos == 5'(d2p_pkg::QUAD_LEN - 1));
                if (r_nl_en) begin
                    w_after_phase = PH_NL;
                end else if (r_ftr_en) begin
                    w_after_phase = PH_FTR;
                end
            end
            PH_NL: begin
                w_char       = d2p_pkg::CHAR_NEWLINE;
                w_phase_last = 1'b1;
                if (r_ftr_en) begin
                    w_after_phase = PH_FTR;
                end
            end
            PH_FTR: begin
                w_char       = d2p_pkg::end_char(r_pos);
                w_phase_last = (r_pos == 5'(d2p_pkg::FTR_LEN - 1));
                w_eob        = w_phase_last;
            end
            default: begin
                w_char = 8'h00;
            end
        endcase

        w_advance  = (r_phase != PH_IDLE) && (!r_out_valid || o_out.ready);
        w_job_last = w_advance && w_phase_last && (w_after_phase == PH_IDLE);
        w_accept   = i_in.valid && i_in.ready;

        n_phase = r_phase;
        n_pos   = r_pos;
        if (w_advance) begin
            if (w_phase_last) begin
                n_phase = w_after_phase;
                n_pos   = 5'd0;
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end
        if (w_accept) begin
            n_phase = w_first_phase;
            n_pos   = 5'd0;
        end
    end

    assign i_in.ready = (r_phase == PH_IDLE) || w_job_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_sent <= 1'b0;
            r_group_bytes <= 16'h0;
            r_group_fill  <= 2'd0;
            r_line_column <= 6'd0;
            r_phase       <= PH_IDLE;
            r_pos         <= 5'd0;
            r_quad_en     <= 1'b0;
            r_nl_en       <= 1'b0;
            r_ftr_en      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (w_accept) begin
                r_header_sent <= n_header_sent;
                r_group_bytes <= n_group_bytes;
                r_group_fill  <= n_group_fill;
                r_line_column <= n_line_column;
                r_quad_en     <= w_quad;
                r_nl_en       <= w_nl;
                r_ftr_en      <= w_ftr;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_quad_chars <= w_quad_chars;
        end
        if (w_advance) begin
            r_out_char <= w_char;
            r_out_eob  <= w_eob;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_char     = r_out_char;
    assign o_out.end_of_block = r_out_eob;

    // The line column only moves in whole quads and wraps at the line length.
    a_column_quads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_column[1:0] == 2'd0)
        && ({1'b0, r_line_column} < 7'(d2p_pkg::LINE_COLUMNS)))
        else $error("line column off a quad boundary or past the line");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_fill != 2'd3)
        else $error("group fill out of range");

    // Before a certificate's header goes out nothing can be pending.
    a_fresh_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_header_sent |-> (r_group_fill == 2'd0) && (r_line_column == 6'd0))
        else $error("state left over without a header");

    // The end marker only ever rides on the footer's closing newline.
    a_eob_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eob) |-> (r_out_char == d2p_pkg::CHAR_NEWLINE))
        else $error("end of block on a character other than newline");

    // A new item is taken only once the job in flight is finishing.
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_phase == PH_IDLE) || (w_advance && w_phase_last
                                              && !r_quad_en && !r_nl_en && !r_ftr_en)
                     || (w_advance && w_phase_last && w_after_phase == PH_IDLE))
        else $error("item accepted while a character job is still running");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DER to PEM encoder: random certificates in, PEM text checked.
module testbench;

    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int ITEM_TARGET  = 410;
    localparam int RX_HOLD_AT   = 30;
    localparam int RX_HOLD_LEN  = 250;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        int         gap;
        bit         drain;
    } t_der_item;

    typedef struct {
        logic [7:0] ch;
        logic       eob;
    } t_pem_char;

    logic i_clk;
    logic i_rst_n;

    d2p_in_if  in_if ();
    d2p_out_if out_if ();

    der_to_pem_base64_encoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string begin_line   = "-----BEGIN CERTIFICATE-----\n";
    string end_line     = "-----END CERTIFICATE-----\n";

    t_der_item der_byte_q[$];
    t_pem_char pem_expect_q[$];

    // Encoder state as seen by the predictor.
    bit          hdr_done;
    logic [15:0] grp_pair;
    int          grp_cnt;
    int          line_col;

    int  err_cnt;
    int  n_in;
    int  n_certs;
    int  n_chars;
    int  n_drains;
    int  max_len;
    int  n_queued;
    int  cycle_cnt;
    bit  in_took;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function void push_char(input logic [7:0] c, input logic eob);
        t_pem_char pc;
        pc.ch  = c;
        pc.eob = eob;
        pem_expect_q.push_back(pc);
    endfunction

    function void put_quad(input logic [23:0] v, input int nbytes);
        push_char(b64_alphabet[v[23:18]], 1'b0);
        push_char(b64_alphabet[v[17:12]], 1'b0);
        push_char(nbytes > 1 ? b64_alphabet[v[11:6]] : d2p_pkg::CHAR_PAD, 1'b0);
        push_char(nbytes > 2 ? b64_alphabet[v[5:0]] : d2p_pkg::CHAR_PAD, 1'b0);
        line_col += 4;
        if (line_col >= d2p_pkg::LINE_COLUMNS) begin
            push_char(d2p_pkg::CHAR_NEWLINE, 1'b0);
            line_col = 0;
        end
    endfunction

    function void predict_pem(input logic [7:0] b, input logic fin);
        int i;
        if (!hdr_done) begin
            for (i = 0; i < begin_line.len(); i++) push_char(begin_line[i], 1'b0);
            hdr_done = 1'b1;
        end
        if (grp_cnt == 2) begin
            put_quad({grp_pair, b}, 3);
            grp_pair = '0;
            grp_cnt  = 0;
        end else if (grp_cnt == 1) begin
            grp_pair[7:0] = b;
            grp_cnt = 2;
        end else begin
            grp_pair = {b, 8'h00};
            grp_cnt  = 1;
        end
        if (fin) begin
            if (grp_cnt != 0) put_quad({grp_pair, 8'h00}, grp_cnt);
            if (line_col != 0) push_char(d2p_pkg::CHAR_NEWLINE, 1'b0);
            for (i = 0; i < end_line.len(); i++) begin
                push_char(end_line[i], i == end_line.len() - 1);
            end
            hdr_done = 1'b0;
            grp_pair = '0;
            grp_cnt  = 0;
            line_col = 0;
        end
    endfunction

    task report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    function void queue_byte(input logic [7:0] b, input logic fin, input int gap,
                             input bit drain);
        t_der_item it;
        it.data  = b;
        it.fin   = fin;
        it.gap   = gap;
        it.drain = drain;
        der_byte_q.push_back(it);
        n_queued++;
    endfunction

    // A certificate of random bytes; a fast one is offered with no gaps.
    function void queue_cert(input int len, input bit fast, input bit drain);
        int i;
        for (i = 0; i < len; i++) begin
            queue_byte(8'($urandom_range(0, 255)), i == len - 1, fast ? 0 : rand_gap(),
                       drain && i == 0);
        end
        if (len > max_len) max_len = len;
    endfunction

    // Sender: offers the next pending item once the previous one was taken.
    always @(negedge i_clk) begin : tx_side
        t_der_item it;
        if (i_rst_n && !(in_if.valid && !in_took)) begin
            if (der_byte_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (der_byte_q[0].gap != 0) begin
                der_byte_q[0].gap--;
                in_if.valid <= 1'b0;
            end else if (der_byte_q[0].drain && pem_expect_q.size() != 0) begin
                in_if.valid <= 1'b0;
            end else begin
                it = der_byte_q.pop_front();
                if (it.drain) n_drains++;
                in_if.valid      <= 1'b1;
                in_if.data_byte  <= it.data;
                in_if.final_byte <= it.fin;
            end
        end
    end

    // Receiver: random stalls, stall-free stretches and one long hold-off.
    always @(negedge i_clk) begin : rx_side
        int  hold_left;
        bit  hold_done;
        int  stall_left;
        int  free_left;
        bit  rdy;
        rdy = 1'b0;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && n_in >= RX_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = RX_HOLD_LEN - 1;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            rdy = 1'b1;
            if (free_left > 0) begin
                free_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                free_left = $urandom_range(20, 80);
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = rand_gap();
            end
        end
        out_if.ready <= rdy;
    end

    // Input and output monitors share the rising edge.
    always @(posedge i_clk) begin : monitor
        t_pem_char exp_c;
        in_took <= in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_pem(in_if.data_byte, in_if.final_byte);
                n_in++;
                if (in_if.final_byte) n_certs++;
            end
            if (out_if.valid && out_if.ready) begin
                n_chars++;
                if (pem_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%h", out_if.out_char));
                end else begin
                    exp_c = pem_expect_q.pop_front();
                    if (out_if.out_char !== exp_c.ch) begin
                        report_mismatch($sformatf("char %0d: out_char 0x%h, expected 0x%h",
                                                  n_chars, out_if.out_char, exp_c.ch));
                    end
                    if (out_if.end_of_block !== exp_c.eob) begin
                        report_mismatch($sformatf("char %0d: end_of_block %b, expected %b",
                                                  n_chars, out_if.end_of_block, exp_c.eob));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d characters outstanding",
                 cycle_cnt, pem_expect_q.size());
        $display("FAIL der_to_pem_base64_encoder_unit");
        $finish;
    end

    initial begin : stimulus
        int  len;
        int  r;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.final_byte = 1'b0;
        out_if.ready     = 1'b0;

        // Directed: one-byte certificates at both extremes, short groups that
        // hit the top of the alphabet, and a partial group after a full one.
        queue_byte(8'h00, 1'b1, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b1, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b1, rand_gap(), 1'b0);
        queue_byte(8'hfb, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'hef, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'hbe, 1'b1, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'hff, 1'b1, rand_gap(), 1'b0);
        queue_byte(8'h00, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'h80, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'h7f, 1'b0, rand_gap(), 1'b0);
        queue_byte(8'h01, 1'b1, rand_gap(), 1'b0);
        queue_cert(5, 1'b0, 1'b0);
        if (max_len < 4) max_len = 4;

        // A full line that ends exactly at the last byte, sent back to back
        // after a drain so that the receiver hold-off backs up the input.
        queue_cert(48, 1'b1, 1'b1);

        while (n_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 12) len = 48 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
            else if (r < 25) len = $urandom_range(1, 3);
            else len = $urandom_range(4, 30);
            if (len > ITEM_TARGET - n_queued) len = ITEM_TARGET - n_queued;
            queue_cert(len, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (der_byte_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (pem_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        #1;
        if (pem_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", pem_expect_q.size()));
        end

        $display("Encoded %0d bytes in %0d certificates (longest %0d bytes) into %0d chars.",
                 n_in, n_certs, max_len, n_chars);
        $display("Covered a %0d-cycle output hold-off and %0d drain pauses; %0d mismatches.",
                 RX_HOLD_LEN, n_drains, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS der_to_pem_base64_encoder_unit");
        end else begin
            $display("FAIL der_to_pem_base64_encoder_unit");
        end
        $finish;
    end

endmodule
